// ===== sv/pwl_pkg.sv =====
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared widths, status codes and controller/datapath interface types for
// the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
package pwl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W       = 7;
    localparam int IDX_W       = 6;
    localparam int WL_W        = 16;
    localparam int REFL_W      = 16;
    localparam int ENTRY_W     = WL_W + REFL_W;
    localparam int PROD_W      = WL_W + REFL_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int DIV_CNT_W   = $clog2(REFL_W);

    typedef enum logic [2:0] {
        ST_INTERP = 3'd0,
        ST_LOW    = 3'd1,
        ST_HIGH   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_NOSEG  = 3'd4
    } t_status;

    typedef struct packed {
        logic    accept;      // request taken this cycle
        logic    load_first;  // first entry on the read port
        logic    load_last;   // last entry on the read port
        logic    scan_start;
        logic    scan_step;
        logic    mul_a;
        logic    mul_b;
        logic    div_init;
        logic    div_step;
        logic    set_res;
        t_status res_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic is_empty;
        logic low_hit;
        logic high_hit;
        logic scan_hit;
        logic seg_bad;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/pwl_ram.sv =====
// ----------------------------------------------------------------------------
// pwl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pwl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwl_ctrl
// Sequencer for table writes and queries: clamp checks, breakpoint scan,
// multiply steps and the bit-serial divide.
// ----------------------------------------------------------------------------
module pwl_ctrl import pwl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_FIRST_W = 12'b0000_0000_0010,
        S_FIRST   = 12'b0000_0000_0100,
        S_LAST_W  = 12'b0000_0000_1000,
        S_LAST    = 12'b0000_0001_0000,
        S_SCAN_W  = 12'b0000_0010_0000,
        S_SCAN    = 12'b0000_0100_0000,
        S_MUL_A   = 12'b0000_1000_0000,
        S_MUL_B   = 12'b0001_0000_0000,
        S_SUM     = 12'b0010_0000_0000,
        S_DIV     = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

    localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(REFL_W - 1);

    t_state               r_state;
    t_state               n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIV_CNT_W-1:0] n_div_cnt;
    t_cmd                 cmd;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        cmd       = '0;
        cmd.res_code = ST_INTERP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_sts.is_query) begin
                        if (i_sts.is_empty) begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_FIRST_W;
                        end
                    end
                end
            end
            S_FIRST_W: n_state = S_FIRST;
            S_FIRST: begin
                cmd.load_first = 1'b1;
                if (i_sts.low_hit) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_LOW;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_LAST_W;
                end
            end
            S_LAST_W: n_state = S_LAST;
            S_LAST: begin
                cmd.load_last = 1'b1;
                if (i_sts.high_hit) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_HIGH;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN_W;
                end
            end
            S_SCAN_W: begin
                cmd.scan_start = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    if (i_sts.seg_bad) begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = ST_NOSEG;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_MUL_A;
                    end
                end else if (i_sts.scan_end) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_NOSEG;
                    n_state      = S_DONE;
                end
            end
            S_MUL_A: begin
                cmd.mul_a = 1'b1;
                n_state   = S_MUL_B;
            end
            S_MUL_B: begin
                cmd.mul_b = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                cmd.div_init = 1'b1;
                n_div_cnt    = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_div_cnt    = r_div_cnt + 1'b1;
                if (r_div_cnt == DivLast) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_INTERP;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule

// ===== sv/pwl_dp.sv =====
// ----------------------------------------------------------------------------
// pwl_dp
// Datapath: breakpoint RAM, count register, clamp and segment compares,
// shared multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
module pwl_dp import pwl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              i_func,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [WL_W-1:0]   i_entry_wavelength,
    input  logic [REFL_W-1:0] i_entry_reflectance,
    input  logic [WL_W-1:0]   i_query_wavelength,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [REFL_W-1:0] o_reflectance,
    output logic [2:0]        o_status,
    input  t_cmd              i_cmd,
    output t_sts              o_sts
);

    logic [CNT_W-1:0]   r_count;
    logic [USED_W-1:0]  used_cnt;
    logic [ADDR_W-1:0]  last_addr;

    logic [WL_W-1:0]    r_q;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_idx;
    logic [ENTRY_W-1:0] r_prev;
    logic [WL_W-1:0]    r_d1;
    logic [WL_W-1:0]    r_d0;
    logic [WL_W-1:0]    r_den;
    logic [REFL_W-1:0]  r_y1;
    logic [PROD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  r_prod;
    logic [WL_W-1:0]    r_rem;
    logic [REFL_W-1:0]  r_quo;
    logic [REFL_W-1:0]  r_res_refl;
    t_status            r_res_st;
    logic               r_out_valid;
    logic [REFL_W-1:0]  r_out_refl;
    t_status            r_out_st;

    logic               ram_we;
    logic [ENTRY_W-1:0] rdata;
    logic [WL_W-1:0]    rd_x;
    logic [REFL_W-1:0]  rd_y;
    logic [WL_W-1:0]    prev_x;
    logic [REFL_W-1:0]  mul_y;
    logic [WL_W-1:0]    mul_d;
    logic [PROD_W-1:0]  prod;
    logic [NUM_W-1:0]   num;
    logic [WL_W:0]      div_t;
    logic               div_ge;
    logic [WL_W:0]      div_diff;
    logic [WL_W-1:0]    n_rem;
    logic [REFL_W-1:0]  n_quo;
    logic [REFL_W-1:0]  res_val;

    // a count past the table depth acts as the full table
    always_comb begin
        if (32'(r_count) > TABLE_DEPTH) begin
            used_cnt = USED_W'(TABLE_DEPTH);
        end else begin
            used_cnt = USED_W'(r_count);
        end
    end
    assign last_addr = ADDR_W'(used_cnt - 1'b1);

    // writes to slots beyond the table are dropped
    assign ram_we = i_cmd.accept && !i_func && (32'(i_entry_index) < TABLE_DEPTH);

    pwl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_entry_index)),
        .i_wdata ({i_entry_wavelength, i_entry_reflectance}),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    assign rd_x   = rdata[ENTRY_W-1:REFL_W];
    assign rd_y   = rdata[REFL_W-1:0];
    assign prev_x = r_prev[ENTRY_W-1:REFL_W];

    assign mul_y = i_cmd.mul_b ? r_y1 : r_prev[REFL_W-1:0];
    assign mul_d = i_cmd.mul_b ? r_d0 : r_d1;
    assign prod  = {{(PROD_W-REFL_W){1'b0}}, mul_y} * {{(PROD_W-WL_W){1'b0}}, mul_d};
    assign num   = {1'b0, r_acc} + {1'b0, r_prod};

    // one quotient bit per step
    assign div_t    = {r_rem, r_quo[REFL_W-1]};
    assign div_ge   = (div_t >= {1'b0, r_den});
    assign div_diff = div_t - {1'b0, r_den};
    assign n_rem    = div_ge ? div_diff[WL_W-1:0] : div_t[WL_W-1:0];
    assign n_quo    = {r_quo[REFL_W-2:0], div_ge};

    always_comb begin
        case (i_cmd.res_code)
            ST_LOW, ST_HIGH: res_val = rd_y;
            ST_INTERP:       res_val = n_quo;
            default:         res_val = '0;
        endcase
    end

    always_comb begin
        o_sts          = '0;
        o_sts.is_query = i_func;
        o_sts.is_empty = (used_cnt == '0);
        o_sts.low_hit  = (r_q <= rd_x);
        o_sts.high_hit = (r_q >= rd_x);
        o_sts.scan_hit = (r_q < rd_x);
        o_sts.seg_bad  = (prev_x > r_q) || (rd_x <= prev_x);
        o_sts.scan_end = (r_idx == last_addr);
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_addr <= '0;
            end else if (i_cmd.load_first) begin
                r_addr <= last_addr;
            end else if (i_cmd.load_last) begin
                r_addr <= ADDR_W'(1);
            end else if (i_cmd.scan_start || i_cmd.scan_step) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_idx <= ADDR_W'(1);
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_q <= i_query_wavelength;
        end
        if (i_cmd.load_first) begin
            r_prev <= rdata;
        end
        if (i_cmd.scan_step) begin
            if (o_sts.scan_hit) begin
                r_d1  <= rd_x - r_q;
                r_d0  <= r_q - prev_x;
                r_den <= rd_x - prev_x;
                r_y1  <= rd_y;
            end else begin
                r_prev <= rdata;
            end
        end
        if (i_cmd.mul_a) begin
            r_acc <= prod;
        end
        if (i_cmd.mul_b) begin
            r_prod <= prod;
        end
        // the quotient fits the result, so the upper numerator bits start the remainder
        if (i_cmd.div_init) begin
            r_rem <= num[NUM_W-2:REFL_W];
            r_quo <= num[REFL_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.set_res) begin
            r_res_refl <= res_val;
            r_res_st   <= i_cmd.res_code;
        end
        if (i_cmd.out_load) begin
            r_out_refl <= r_res_refl;
            r_out_st   <= r_res_st;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_reflectance = r_out_refl;
    assign o_status      = r_out_st;

endmodule

// ===== sv/piecewise_linear_table_interpolator_top.sv =====
// Paths from accept to output register load: empty table, low clamp, high
// clamp, and interpolation, which scans up to the first breakpoint above the
// query (index 1 to 63). A write request is taken while idle and leaves it idle.
// Throughput: one request at a time; the next is taken no earlier than the cycle
// after the result loads, so a query holds off the input until then.
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator_top
// Breakpoint table with clamped linear interpolation of reflectance. Reset
// clears the entry count, control state and output valid; table contents stay.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator_top import pwl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_func,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [WL_W-1:0]   i_entry_wavelength,
    input  logic [REFL_W-1:0] i_entry_reflectance,
    input  logic [WL_W-1:0]   i_query_wavelength,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [REFL_W-1:0] o_reflectance,
    output logic [2:0]        o_status
);

    t_cmd cmd;
    t_sts sts;

    pwl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pwl_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_func              (i_func),
        .i_entry_index       (i_entry_index),
        .i_entry_wavelength  (i_entry_wavelength),
        .i_entry_reflectance (i_entry_reflectance),
        .i_query_wavelength  (i_query_wavelength),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_reflectance       (o_reflectance),
        .o_status            (o_status),
        .i_cmd               (cmd),
        .o_sts               (sts)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise linear table interpolator. Loads
// breakpoint tables of several sizes and shapes, sweeps reflectance lookups
// under random idling on both channels, and compares every result with a
// lookup kept in step with the block.
// ----------------------------------------------------------------------------
module tb;
    import pwl_pkg::*;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam int FILL_SPREAD   = 0;
    localparam int FILL_CLUSTER  = 1;
    localparam int FILL_UNSORTED = 2;
    localparam int FILL_EXTREME  = 3;

    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 4000;
    localparam int NUM_PHASES   = 12;

    typedef struct packed {
        logic [REFL_W-1:0] refl;
        t_status           status;
    } t_lookup;

    class reflectance_scoreboard;
        logic [WL_W-1:0]   wl_tbl   [TABLE_DEPTH];
        logic [REFL_W-1:0] refl_tbl [TABLE_DEPTH];
        logic [CNT_W-1:0]  entry_count;
        t_lookup           lookup_q [$];
        int                errors;
        int                writes;
        int                lookups [5];

        function new();
            errors      = 0;
            writes      = 0;
            entry_count = '0;
            foreach (lookups[i]) lookups[i] = 0;
            foreach (wl_tbl[i]) begin
                wl_tbl[i]   = '0;
                refl_tbl[i] = '0;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function t_lookup predict_lookup(logic [WL_W-1:0] q);
            t_lookup         r;
            int              n;
            longint unsigned x0;
            longint unsigned x1;
            longint unsigned y0;
            longint unsigned y1;
            longint unsigned qq;
            r.refl   = '0;
            r.status = ST_NOSEG;
            n  = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
            qq = longint'(q);
            if (n == 0) begin
                r.status = ST_EMPTY;
                return r;
            end
            if (q <= wl_tbl[0]) begin
                r.refl   = refl_tbl[0];
                r.status = ST_LOW;
                return r;
            end
            if (q >= wl_tbl[n-1]) begin
                r.refl   = refl_tbl[n-1];
                r.status = ST_HIGH;
                return r;
            end
            // first breakpoint above the query closes the segment
            for (int i = 0; i + 1 < n; i++) begin
                if (q < wl_tbl[i+1]) begin
                    x0 = longint'(wl_tbl[i]);
                    x1 = longint'(wl_tbl[i+1]);
                    if (x0 > qq || x1 <= x0) break;
                    y0 = longint'(refl_tbl[i]);
                    y1 = longint'(refl_tbl[i+1]);
                    r.refl   = REFL_W'((y0 * (x1 - qq) + y1 * (qq - x0)) / (x1 - x0));
                    r.status = ST_INTERP;
                    return r;
                end
            end
            return r;
        endfunction

        function void note_request(logic func, logic [IDX_W-1:0] idx,
                                   logic [WL_W-1:0] wl, logic [REFL_W-1:0] refl,
                                   logic [WL_W-1:0] q);
            if (func == FUNC_WRITE) begin
                if (idx < TABLE_DEPTH) begin
                    wl_tbl[idx]   = wl;
                    refl_tbl[idx] = refl;
                end
                writes++;
            end else begin
                lookup_q = {lookup_q, predict_lookup(q)};
            end
        endfunction

        task check_result(logic [REFL_W-1:0] refl, logic [2:0] status);
            t_lookup e;
            if (lookup_q.size() == 0) begin
                report($sformatf("result with none pending: refl=%h status=%0d",
                                 refl, status));
                return;
            end
            e = lookup_q.pop_front();
            if (refl !== e.refl) begin
                report($sformatf("reflectance %h, want %h (status %s)",
                                 refl, e.refl, e.status.name()));
            end
            if (status !== e.status) begin
                report($sformatf("status %0d, want %s", status, e.status.name()));
            end
            lookups[int'(e.status)]++;
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_func;
    logic [IDX_W-1:0]  i_entry_index;
    logic [WL_W-1:0]   i_entry_wavelength;
    logic [REFL_W-1:0] i_entry_reflectance;
    logic [WL_W-1:0]   i_query_wavelength;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [REFL_W-1:0] o_reflectance;
    logic [2:0]        o_status;

    reflectance_scoreboard sb;
    int idle_pct     = 34;
    int quiet_cycles = 0;
    int n_requests   = 0;
    int n_settings   = 0;

    int phase_count [NUM_PHASES] = '{2, 64, 127, 1, 0, -1, 64, -1, -1, -1, -1, -1};
    int phase_fill  [NUM_PHASES] = '{FILL_SPREAD, FILL_CLUSTER, FILL_EXTREME,
                                     FILL_SPREAD, FILL_SPREAD, FILL_SPREAD,
                                     FILL_SPREAD, FILL_UNSORTED, FILL_CLUSTER,
                                     FILL_EXTREME, FILL_UNSORTED, FILL_SPREAD};

    piecewise_linear_table_interpolator_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_func              (i_func),
        .i_entry_index       (i_entry_index),
        .i_entry_wavelength  (i_entry_wavelength),
        .i_entry_reflectance (i_entry_reflectance),
        .i_query_wavelength  (i_query_wavelength),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_reflectance       (o_reflectance),
        .o_status            (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_reflectance, o_status);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles", quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(logic func, logic [IDX_W-1:0] idx, logic [WL_W-1:0] wl,
                                logic [REFL_W-1:0] refl, logic [WL_W-1:0] q);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_func              <= func;
        i_entry_index       <= idx;
        i_entry_wavelength  <= wl;
        i_entry_reflectance <= refl;
        i_query_wavelength  <= q;
        // hold the request until the block takes it
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(func, idx, wl, refl, q);
        n_requests++;
        @(negedge i_clk);
    endtask

    task automatic write_entry(logic [IDX_W-1:0] idx, logic [WL_W-1:0] wl,
                               logic [REFL_W-1:0] refl);
        send_request(FUNC_WRITE, idx, wl, refl, WL_W'($urandom));
    endtask

    task automatic query_at(logic [WL_W-1:0] q);
        send_request(FUNC_QUERY, IDX_W'($urandom), WL_W'($urandom), REFL_W'($urandom), q);
    endtask

    task automatic set_entry_count(logic [CNT_W-1:0] cnt);
        // drain pending lookups, then let a trailing write settle
        i_in_valid <= 1'b0;
        while (sb.lookup_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.entry_count = cnt;
        n_settings++;
    endtask

    task automatic fill_table(int n, int fill);
        logic [WL_W-1:0]   wls [$];
        logic [REFL_W-1:0] refl;
        int                span;
        int                base;
        span = 4 * n;
        base = $urandom_range(0, 65535 - span);
        for (int i = 0; i < n; i++) begin
            if (fill == FILL_CLUSTER) wls = {wls, WL_W'(base + $urandom_range(0, span))};
            else wls = {wls, WL_W'($urandom)};
        end
        if (fill != FILL_UNSORTED) wls.sort();
        if (fill == FILL_EXTREME && n > 1) begin
            wls[0]   = '0;
            wls[n-1] = '1;
        end
        for (int i = 0; i < n; i++) begin
            if (fill == FILL_EXTREME) refl = (i % 2 != 0) ? 16'hFFFF : 16'h0000;
            else refl = REFL_W'($urandom);
            write_entry(IDX_W'(i), wls[i], refl);
        end
    endtask

    task automatic random_query(int n);
        int              sel;
        int              k;
        logic [WL_W-1:0] lo;
        logic [WL_W-1:0] hi;
        logic [WL_W-1:0] q;
        sel = $urandom_range(0, 99);
        k   = (n > 0) ? $urandom_range(0, n - 1) : 0;
        lo  = sb.wl_tbl[0];
        hi  = sb.wl_tbl[(n > 0) ? n - 1 : 0];
        if (sel < 35) q = WL_W'($urandom);
        else if (sel < 65) q = (lo < hi) ? WL_W'($urandom_range(lo, hi)) : WL_W'($urandom);
        else if (sel < 80) q = sb.wl_tbl[k];
        else if (sel < 90) q = sel[0] ? sb.wl_tbl[k] + 1'b1 : sb.wl_tbl[k] - 1'b1;
        else q = sel[0] ? '1 : '0;
        query_at(q);
    endtask

    initial begin
        int cnt;
        int used;
        int n_items;
        sb = new();
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        i_in_valid          = 1'b0;
        i_func              = FUNC_WRITE;
        i_entry_index       = '0;
        i_entry_wavelength  = '0;
        i_entry_reflectance = '0;
        i_query_wavelength  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table
        set_entry_count(CNT_W'(0));
        query_at(16'h0000);
        query_at(16'hFFFF);

        // single entry: low clamp wins at the breakpoint itself
        write_entry(IDX_W'(0), 16'h8000, 16'h1234);
        set_entry_count(CNT_W'(1));
        query_at(16'h7FFF);
        query_at(16'h8000);
        query_at(16'h8001);
        query_at(16'h0000);
        query_at(16'hFFFF);

        // full-scale steps, exact breakpoints and the span ends
        write_entry(IDX_W'(0), 16'h0000, 16'hFFFF);
        write_entry(IDX_W'(1), 16'h0100, 16'h0000);
        write_entry(IDX_W'(2), 16'h0101, 16'hFFFF);
        write_entry(IDX_W'(3), 16'hFFFF, 16'h0000);
        set_entry_count(CNT_W'(4));
        query_at(16'h0000);
        query_at(16'h0080);
        query_at(16'h0100);
        query_at(16'h0101);
        query_at(16'h8000);
        query_at(16'hFFFE);
        query_at(16'hFFFF);

        for (int p = 0; p < NUM_PHASES; p++) begin
            cnt      = (phase_count[p] < 0) ? $urandom_range(3, 63) : phase_count[p];
            used     = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
            n_items  = (used <= 1) ? 40 : 100;
            idle_pct = (p == 5 || p == 6) ? 0 : 34;
            set_entry_count(CNT_W'(cnt));
            fill_table(used, phase_fill[p]);
            for (int i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 99) < 8) begin
                    write_entry(IDX_W'($urandom), WL_W'($urandom), REFL_W'($urandom));
                end else begin
                    random_query(used);
                end
            end
        end

        i_in_valid <= 1'b0;
        idle_pct = 34;
        while (sb.lookup_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d requests: %0d table writes, %0d entry-count settings",
                 n_requests, sb.writes, n_settings);
        $display("lookups: %0d interpolated, %0d clamped low, %0d clamped high, %0d empty",
                 sb.lookups[ST_INTERP], sb.lookups[ST_LOW], sb.lookups[ST_HIGH],
                 sb.lookups[ST_EMPTY]);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
